// ----- hw/rtl/vema_pkg.sv -----
// package for the velocity estimator with moving average
// shared types and constants; no dependencies
package vema_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned TimeW  = 20;
  localparam int unsigned WinW   = 10;
  localparam int unsigned ScaleW = 20;
  localparam logic [ScaleW-1:0] UsPerSec = 20'd1000000;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

// ----- hw/rtl/vema_div.sv -----
// shared radix-2 restoring divider, one quotient bit per cycle
// magnitude divide with sign applied on the result; uses vema_pkg
module vema_div
  import vema_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] num;
  logic [31:0] den;
  logic [32:0] rem;
  logic [63:0] quo;
  logic [6:0]  cnt;
  logic        busy;
  logic        neg;
  logic        done;
  logic [32:0] rem_sh;
  logic [33:0] diff;

  assign rem_sh = {rem[31:0], num[63]};
  assign diff   = {1'b0, rem_sh} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        num  <= req.num;
        den  <= req.den;
        neg  <= req.neg;
        rem  <= '0;
        quo  <= '0;
        cnt  <= 7'd0;
      end else if (busy) begin
        num <= {num[62:0], 1'b0};
        if (!diff[33]) begin
          rem <= diff[32:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, (neg ? (~quo + 64'd1) : quo)};

endmodule

// ----- hw/rtl/vema_hist.sv -----
// history store for one channel, one address a cycle: written when we is set, read every cycle
// read data registered; no dependencies
module vema_hist #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/velocity_estimator_moving_average.sv -----
// velocity estimator: finite difference, integer root, boxcar mean
// uses vema_pkg, vema_div, vema_hist
//
// channel   dir  signals
// s_axis    in   s_axis_tvalid/tready/tdata (pos_x,pos_y,pos_z,elapsed_us)
// m_axis    out  m_axis_tvalid/tready/tdata/tuser (vel,speed,avg,time_error)
// cfg       in   cfg_we/cfg_wdata (window_length)
//
// after reset a clearing pass writes every history row
// one item is accepted, then takes three divisions (none with zero time),
// the squares of three lanes, 33 root steps, one history write, the window
// reads and four divisions for the means; every division uses the one shared divider
// s_axis_tready is low from acceptance until the result is taken
module velocity_estimator_moving_average
  import vema_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // pos_x, pos_y, pos_z, elapsed_us, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata,  // vel_x, vel_y, vel_z, speed, avg_x..avg_speed
  output logic         m_axis_tuser,  // time_error
  input  logic         cfg_we,
  input  logic [WinW-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_VDIV  = 11'b00000000100,
    S_VWAIT = 11'b00000001000,
    S_SQ    = 11'b00000010000,
    S_ROOT  = 11'b00000100000,
    S_WR    = 11'b00001000000,
    S_SUM   = 11'b00010000000,
    S_ADIV  = 11'b00100000000,
    S_AWAIT = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  logic [WinW-1:0] window_length;
  logic signed [31:0] px, py, pz;
  logic signed [31:0] prev_x, prev_y, prev_z;
  logic prev_valid;
  logic [TimeW-1:0] dt;
  logic [AW-1:0] newest_pointer, addr;
  logic [CW-1:0] cnt;
  logic [CW-1:0] n;
  logic [1:0] ch;
  logic signed [31:0] vel [3];
  logic [31:0] spd;
  logic [65:0] sq;
  logic [65:0] rem;
  logic [33:0] root;
  logic [5:0] rstep;
  logic signed [63:0] acc [3];
  logic [63:0] accs;
  logic [31:0] avg [4];
  logic we;
  logic [31:0] wd [4];
  logic [31:0] rd [4];
  logic rd_vld;
  div_req_t dreq;
  div_rsp_t drsp;

  vema_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  for (genvar g = 0; g < 4; g++) begin : g_hist
    vema_hist #(.DEPTH(MAX_WINDOW), .AW(AW)) u_hist (
      .clk(clk), .we(we), .addr(addr), .wdata(wd[g]), .rdata(rd[g]));
  end

  // window clamp
  always_comb begin
    if (window_length == '0) n = CW'(1);
    else if ({{(32-WinW){1'b0}}, window_length} > MAX_WINDOW) n = CW'(MAX_WINDOW);
    else n = CW'(window_length);
  end

  // velocity numerator: delta times one million, 54 bits signed
  logic signed [32:0] delta;
  logic signed [63:0] prod;
  logic signed [31:0] cur_p, cur_prev;
  always_comb begin
    case (ch)
      2'd0: begin cur_p = px; cur_prev = prev_x; end
      2'd1: begin cur_p = py; cur_prev = prev_y; end
      default: begin cur_p = pz; cur_prev = prev_z; end
    endcase
    delta = 33'(cur_p) - 33'(cur_prev);
    prod  = 64'(delta) * $signed({1'b0, UsPerSec});
  end

  // saturated quotient
  logic signed [63:0] q;
  logic signed [31:0] qsat;
  assign q = signed'(drsp.quo);
  always_comb begin
    if (q > 64'sd2147483647) qsat = 32'h7fffffff;
    else if (q < -64'sd2147483648) qsat = 32'h80000000;
    else qsat = q[31:0];
  end

  // root step
  logic [65:0] trial;
  assign trial = {32'd0, root[31:0], 2'b01};
  logic [65:0] rem_sh;
  assign rem_sh = {rem[63:0], sq[65:64]};

  // square of one lane, registered into sq via accumulate over the three lanes
  logic signed [63:0] vsq;
  assign vsq = vel[ch] * vel[ch];

  // circular pointer arithmetic modulo the history depth
  logic [AW-1:0] ptr_next, rd_addr;
  assign ptr_next = (newest_pointer == AW'(MAX_WINDOW - 1)) ? '0
                                                            : AW'(newest_pointer + AW'(1));
  assign rd_addr = (cnt > CW'(newest_pointer)) ?
                   AW'(CW'(newest_pointer) + CW'(MAX_WINDOW) - cnt) :
                   AW'(CW'(newest_pointer) - cnt);

  always_comb begin
    we = (state == S_CLR) || (state == S_WR);
    addr = (state == S_CLR) ? cnt[AW-1:0] :
           (state == S_WR) ? ptr_next : rd_addr;
    for (int i = 0; i < 3; i++) wd[i] = (state == S_CLR) ? 32'd0 : vel[i];
    // spd is registered in S_WR but the write happens that same cycle
    wd[3] = (state == S_CLR) ? 32'd0 :
            ((root[33:32] != 2'b00) ? 32'hffffffff : root[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      window_length <= WinW'(1);
      prev_valid <= 1'b0;
      newest_pointer <= '0;
      cnt <= '0;
      dreq.start <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      if (cfg_we) window_length <= cfg_wdata;
      dreq.start <= 1'b0;
      rd_vld <= 1'b0;
      unique case (state)
        S_CLR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(MAX_WINDOW - 1)) begin
            cnt <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            px <= s_axis_tdata[31:0];
            py <= s_axis_tdata[63:32];
            pz <= s_axis_tdata[95:64];
            dt <= s_axis_tdata[115:96];
            if (!prev_valid) begin
              prev_x <= s_axis_tdata[31:0];
              prev_y <= s_axis_tdata[63:32];
              prev_z <= s_axis_tdata[95:64];
              prev_valid <= 1'b1;
            end
            ch <= 2'd0;
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (dt == '0) begin
            vel[ch] <= '0;
            if (ch == 2'd2) begin
              ch <= 2'd0; sq <= '0; state <= S_SQ;
            end else ch <= ch + 2'd1;
          end else begin
            dreq.start <= 1'b1;
            dreq.neg <= prod[63];
            dreq.num <= prod[63] ? (~prod + 64'sd1) : prod;
            dreq.den <= 32'(dt);
            state <= S_VWAIT;
          end
        end
        S_VWAIT: begin
          if (drsp.done) begin
            vel[ch] <= qsat;
            if (ch == 2'd2) begin
              ch <= 2'd0; sq <= '0; state <= S_SQ;
            end else begin
              ch <= ch + 2'd1; state <= S_VDIV;
            end
          end
        end
        S_SQ: begin
          sq <= sq + 66'(unsigned'(vsq));
          if (ch == 2'd2) begin
            rem <= '0; root <= '0; rstep <= '0; state <= S_ROOT;
          end else ch <= ch + 2'd1;
        end
        S_ROOT: begin
          // two bits of radicand a step, one root bit
          sq <= {sq[63:0], 2'b00};
          if (rem_sh >= trial) begin
            rem <= rem_sh - trial;
            root <= {root[32:0], 1'b1};
          end else begin
            rem <= rem_sh;
            root <= {root[32:0], 1'b0};
          end
          rstep <= rstep + 6'd1;
          if (rstep == 6'd32) state <= S_WR;
        end
        S_WR: begin
          spd <= (root[33:32] != 2'b00) ? 32'hffffffff : root[31:0];
          newest_pointer <= ptr_next;
          prev_x <= px; prev_y <= py; prev_z <= pz;
          for (int i = 0; i < 3; i++) acc[i] <= '0;
          accs <= '0;
          cnt <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          if (cnt < n) begin
            cnt <= cnt + CW'(1);
            rd_vld <= 1'b1;
          end
          // read data of the previous cycle's address is valid now
          if (rd_vld) begin
            for (int i = 0; i < 3; i++) acc[i] <= acc[i] + 64'(signed'(rd[i]));
            accs <= accs + 64'(rd[3]);
          end
          if (cnt == n && !rd_vld) begin
            ch <= 2'd0; state <= S_ADIV;
          end
        end
        S_ADIV: begin
          dreq.start <= 1'b1;
          dreq.den <= 32'(n);
          if (ch == 2'd3) begin
            dreq.neg <= 1'b0; dreq.num <= accs;
          end else begin
            dreq.neg <= acc[ch][63];
            dreq.num <= acc[ch][63] ? (~acc[ch] + 64'sd1) : acc[ch];
          end
          state <= S_AWAIT;
        end
        S_AWAIT: begin
          if (drsp.done) begin
            avg[ch] <= drsp.quo[31:0];
            if (ch == 2'd3) state <= S_OUT;
            else begin
              ch <= ch + 2'd1; state <= S_ADIV;
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_CLR;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {avg[3], avg[2], avg[1], avg[0], spd, vel[2], vel[1], vel[0]};
  assign m_axis_tuser  = (dt == '0);

  assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output both open");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
    else $error("not idle after result taken");
  assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == S_VWAIT || state == S_AWAIT))
    else $error("divider finished out of sequence");

endmodule

// ----- tb/tb_top.sv -----
// testbench for velocity_estimator_moving_average: streams position samples in,
// predicts velocity, speed and window means, and checks every result
// depends on vema_pkg and the velocity estimator rtl
`timescale 1ns / 1ps

module tb_top
  import vema_pkg::*;
();

  localparam int unsigned HIST_DEPTH = 512;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct {
    int          vel_x;
    int          vel_y;
    int          vel_z;
    int unsigned speed;
    int          avg_x;
    int          avg_y;
    int          avg_z;
    int unsigned avg_speed;
    bit          time_error;
  } motion_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;   // pos_x, pos_y, pos_z, elapsed_us, pad
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [255:0] m_axis_tdata;   // vel_x, vel_y, vel_z, speed, avg_x, avg_y, avg_z, avg_speed
  logic         m_axis_tuser;   // time_error
  logic         cfg_we;
  logic [WinW-1:0] cfg_wdata;

  velocity_estimator_moving_average #(.MAX_WINDOW(HIST_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predictor state
  int          last_x, last_y, last_z;
  bit          have_last;
  int          hist_x[HIST_DEPTH];
  int          hist_y[HIST_DEPTH];
  int          hist_z[HIST_DEPTH];
  int unsigned hist_speed[HIST_DEPTH];
  int unsigned newest;
  int unsigned window_len;

  motion_t expected_motion[$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned error_flags_seen;
  bit          calm;    // no idling on either side when set
  int          walk_x, walk_y, walk_z;

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int axis_rate(longint delta, int unsigned dt);
    longint dl;
    dl = dt;
    if (dt == 0) return 0;
    return clamp32((delta * 64'sd1000000) / dl);
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic motion_t predict_motion(int px, int py, int pz, int unsigned dt);
    motion_t m;
    longint unsigned sq;
    logic [63:0] root;
    int unsigned n;
    int unsigned idx;
    longint sx, sy, sz;
    longint unsigned ss;
    sx = 0; sy = 0; sz = 0; ss = 0;
    if (!have_last) begin
      last_x = px; last_y = py; last_z = pz;
      have_last = 1'b1;
    end
    m.vel_x = axis_rate(longint'(px) - longint'(last_x), dt);
    m.vel_y = axis_rate(longint'(py) - longint'(last_y), dt);
    m.vel_z = axis_rate(longint'(pz) - longint'(last_z), dt);
    sq = longint'(m.vel_x) * longint'(m.vel_x);
    sq = sq + longint'(m.vel_y) * longint'(m.vel_y);
    sq = sq + longint'(m.vel_z) * longint'(m.vel_z);
    root = isqrt64(sq);
    m.speed = (root > 64'hffffffff) ? 32'hffffffff : root[31:0];
    newest = (newest + 1) % HIST_DEPTH;
    hist_x[newest] = m.vel_x;
    hist_y[newest] = m.vel_y;
    hist_z[newest] = m.vel_z;
    hist_speed[newest] = m.speed;
    n = window_len;
    if (n < 1) n = 1;
    if (n > HIST_DEPTH) n = HIST_DEPTH;
    idx = newest;
    for (int k = 0; k < n; k++) begin
      sx += hist_x[idx];
      sy += hist_y[idx];
      sz += hist_z[idx];
      ss += hist_speed[idx];
      idx = (idx == 0) ? HIST_DEPTH - 1 : idx - 1;
    end
    last_x = px; last_y = py; last_z = pz;
    m.avg_x = int'(sx / longint'(n));
    m.avg_y = int'(sy / longint'(n));
    m.avg_z = int'(sz / longint'(n));
    m.avg_speed = int'(ss / longint'(n));
    m.time_error = (dt == 0);
    return m;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  task automatic send_sample(int px, int py, int pz, int unsigned dt);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {4'b0, dt[19:0], pz, py, px};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_motion.push_back(predict_motion(px, py, pz, dt[19:0]));
  endtask

  // stop sending and let every pending request finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(int unsigned value);
    cfg_wdata <= value[WinW-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_len = value[WinW-1:0];
  endtask

  task automatic test_first_sample();
    send_sample(32'sh12345678, -32'sh00abcdef, 32'sh7fffffff, 1000);
    send_sample(32'sh12345678, -32'sh00abcdef, 32'sh7fffffff, 1);
  endtask

  task automatic test_saturation();
    send_sample(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1);
    send_sample(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1);
    send_sample(32'sh7fffffff, 32'sh80000000, 0, 20'hfffff);
    send_sample(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 20'hfffff);
    send_sample(0, 0, 0, 20'h80000);
    send_sample(-1, 1, -1, 1);
  endtask

  task automatic test_time_error();
    send_sample(32'sh00010000, 32'sh00020000, -32'sh00030000, 0);
    send_sample(32'sh00050000, 32'sh00020000, -32'sh00030000, 0);
    send_sample(32'sh00060000, 32'sh00030000, -32'sh00020000, 500);
  endtask

  task automatic test_window_edges();
    drain();
    write_window(HIST_DEPTH);   // longer than the samples seen so far
    send_sample(32'sh00100000, 0, 0, 1000);
    send_sample(32'sh00200000, 32'sh00100000, -32'sh00100000, 1000);
    drain();
    write_window(0);            // treated as one
    send_sample(32'sh00300000, 32'sh00200000, -32'sh00200000, 250);
    send_sample(32'sh00100000, 32'sh00200000, -32'sh00200000, 3);
    drain();
    write_window(1023);         // clamped to the history depth
    send_sample(32'sh00000000, 32'sh00100000, 32'sh00100000, 77);
    send_sample(32'sh7fff0000, -32'sh7fff0000, 32'sh00100000, 20'hfffff);
    drain();
    write_window(2);
    send_sample(32'sh7fff0000, -32'sh7fff0000, 32'sh00100000, 0);
    send_sample(32'sh7ff00000, -32'sh7ff00000, 32'sh00000000, 16);
  endtask

  task automatic send_random(int unsigned count);
    int unsigned r;
    int unsigned dt;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        walk_x = $urandom; walk_y = $urandom; walk_z = $urandom;
        dt = $urandom_range(0, 20'hfffff);
      end else begin
        walk_x += $signed($urandom_range(0, 2 << 20)) - (1 << 20);
        walk_y += $signed($urandom_range(0, 2 << 20)) - (1 << 20);
        walk_z += $signed($urandom_range(0, 2 << 16)) - (1 << 16);
        dt = (r < 13) ? 0 : $urandom_range(1, 50000);
      end
      send_sample(walk_x, walk_y, walk_z, dt);
    end
  endtask

  task automatic test_random();
    int unsigned windows[6] = '{3, 37, 200, 512, 1, 700};
    for (int p = 0; p < 6; p++) begin
      drain();
      write_window(windows[p]);
      calm = (p == 2);
      send_random(92);
    end
    calm = 1'b0;
  endtask

  // receiver side: random back-pressure
  int unsigned hold_cnt;
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      hold_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                               : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    motion_t e;
    int unsigned got[8];
    int unsigned want[8];
    string names[8] = '{"vel_x", "vel_y", "vel_z", "speed",
                        "avg_x", "avg_y", "avg_z", "avg_speed"};
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (m_axis_tuser) error_flags_seen <= error_flags_seen + 1;
      if (expected_motion.size() == 0) begin
        $display("%0t: result with no request waiting", $time);
        errors = errors + 1;
      end else begin
        e = expected_motion.pop_front();
        want = '{e.vel_x, e.vel_y, e.vel_z, e.speed,
                 e.avg_x, e.avg_y, e.avg_z, e.avg_speed};
        for (int f = 0; f < 8; f++) begin
          got[f] = m_axis_tdata[32*f +: 32];
          if (got[f] !== want[f]) begin
            $display("%0t: %s expected %h actual %h", $time, names[f], want[f], got[f]);
            errors = errors + 1;
          end
        end
        if (m_axis_tuser !== e.time_error) begin
          $display("%0t: time_error expected %b actual %b", $time, e.time_error,
                   m_axis_tuser);
          errors = errors + 1;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int unsigned idle_cycles;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_cnt = 0;
    idle_cycles = 0;
    errors = 0;
    results_seen = 0;
    error_flags_seen = 0;
    calm = 1'b0;
    have_last = 1'b0;
    last_x = 0; last_y = 0; last_z = 0;
    newest = 0;
    window_len = 1;
    walk_x = 0; walk_y = 0; walk_z = 0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_x[i] = 0; hist_y[i] = 0; hist_z[i] = 0; hist_speed[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_sample();
    test_saturation();
    test_time_error();
    test_window_edges();
    test_random();
    drain();
    $display("covered %0d results, %0d with zero elapsed time, windows 0 to 1023",
             results_seen, error_flags_seen);
    $display("including first sample, velocity clamping and long-window averaging");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
